// ===== rtl/core/pwcrc_pkg.sv =====
`default_nettype none
package pwcrc_pkg;

   localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
   localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
   localparam logic [31:0] SIG_RESET = 32'h4D52_4C41;
   localparam logic [7:0]  KEY_RESET = 8'hB3;

   // Container header length in bytes; bytes 0-3 of it hold the signature.
   localparam logic [31:0] HEADER_BYTES = 32'd512;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_WRAP_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SIGNATURE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_XOR_KEY   = 2'd2;

   localparam logic MODE_WRAP   = 1'b0;
   localparam logic MODE_UNWRAP = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SHORT     = 2'd1;
   localparam logic [1:0] STATUS_BAD_SIG   = 2'd2;

   typedef struct packed {
      logic [7:0] data_in;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_valid;
      logic        end_of_stream;
      logic [1:0]  status;
      logic [31:0] crc_value;
      logic [31:0] byte_length;
   } rsp_type;

   // One byte of a reflected CRC-32 update: eight shift-and-xor steps.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/payload_wrap_crc32_xor_top.sv =====
`default_nettype none
// Byte-stream container wrapper/unwrapper. One byte is taken per cycle while
// req_ready is high, and its result (if any) is held in a single output register;
// a new byte is accepted whenever that register is empty or being drained in the
// same cycle, so the sustained rate is one byte per clock while rsp_ready stays high. The CRC-32 update,
// signature compare and key XOR all happen in the cycle the byte is accepted.
// In wrap mode every byte gives a result and the last one carries the final
// CRC and the saturating byte count. In unwrap mode the first 512 header bytes
// produce no result unless one of them is the last byte; payload bytes are
// passed XORed with the key only if header bytes 0-3 matched the signature.
// Configuration writes take effect at once and should only be made between
// streams or while the block is idle.
module payload_wrap_crc32_xor_top (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  pwcrc_pkg::req_type              req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output pwcrc_pkg::rsp_type                    rsp_data,
   input  wire                                   csr_we,
   input  wire  [pwcrc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [31:0]                           csr_wdata
);

   logic        wrap_mode_ff;
   logic [31:0] signature_ff;
   logic [7:0]  xor_key_ff;

   logic [31:0] crc_ff, crc_in;
   logic [31:0] count_ff, count_in;
   logic        sig_match_ff, sig_match_in;

   logic               rsp_valid_ff, rsp_valid_in;
   pwcrc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        accept;
   logic [31:0] pos;
   logic [31:0] len;
   logic [31:0] crc_next;
   logic [7:0]  want;
   logic        match_now;
   logic        payload;
   logic        emit;
   logic        valid_byte;
   logic [1:0]  status;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      pos       = count_ff;
      len       = (pos == pwcrc_pkg::ALL_ONES) ? pwcrc_pkg::ALL_ONES : pos + 32'd1;
      crc_next  = pwcrc_pkg::crc_byte(crc_ff, req_data.data_in);
      want      = signature_ff[{pos[1:0], 3'b000} +: 8];
      match_now = sig_match_ff;
      if (pos < 32'd4 && want != req_data.data_in) begin
         match_now = 1'b0;
      end
      payload = (pos >= pwcrc_pkg::HEADER_BYTES);
      status  = pwcrc_pkg::STATUS_OK;

      if (wrap_mode_ff == pwcrc_pkg::MODE_WRAP) begin
         emit       = 1'b1;
         valid_byte = 1'b1;
      end else begin
         emit       = payload || req_data.last_in;
         valid_byte = payload && match_now;
         if (req_data.last_in) begin
            if (len <= pwcrc_pkg::HEADER_BYTES) begin
               status = pwcrc_pkg::STATUS_SHORT;
            end else if (!match_now) begin
               status = pwcrc_pkg::STATUS_BAD_SIG;
            end
         end
      end

      rsp_data_in.out_byte      = valid_byte ? (req_data.data_in ^ xor_key_ff) : 8'd0;
      rsp_data_in.out_valid     = valid_byte;
      rsp_data_in.end_of_stream = req_data.last_in;
      rsp_data_in.status        = status;
      rsp_data_in.crc_value     = (wrap_mode_ff == pwcrc_pkg::MODE_WRAP && req_data.last_in)
                                  ? (crc_next ^ pwcrc_pkg::ALL_ONES) : 32'd0;
      rsp_data_in.byte_length   = req_data.last_in ? len : 32'd0;

      // Stream state; the last byte returns everything to its start values.
      crc_in       = crc_ff;
      count_in     = count_ff;
      sig_match_in = sig_match_ff;
      if (accept) begin
         if (req_data.last_in) begin
            crc_in       = pwcrc_pkg::ALL_ONES;
            count_in     = 32'd0;
            sig_match_in = 1'b1;
         end else begin
            count_in = len;
            if (wrap_mode_ff == pwcrc_pkg::MODE_WRAP) begin
               crc_in = crc_next;
            end else begin
               sig_match_in = match_now;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_mode_ff <= pwcrc_pkg::MODE_WRAP;
         signature_ff <= pwcrc_pkg::SIG_RESET;
         xor_key_ff   <= pwcrc_pkg::KEY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pwcrc_pkg::REG_WRAP_MODE: wrap_mode_ff <= csr_wdata[0];
            pwcrc_pkg::REG_SIGNATURE: signature_ff <= csr_wdata;
            pwcrc_pkg::REG_XOR_KEY:   xor_key_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= pwcrc_pkg::ALL_ONES;
         count_ff     <= 32'd0;
         sig_match_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         sig_match_ff <= sig_match_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire

// ===== bench/tb_payload_wrap_crc32_xor_top.sv =====
`timescale 1ns / 100ps

module tb_payload_wrap_crc32_xor_top;

   localparam logic [pwcrc_pkg::CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;
   localparam int HDR = int'(pwcrc_pkg::HEADER_BYTES);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pwcrc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pwcrc_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [pwcrc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // Register copies and stream state as the block should hold them.
   logic        cfg_mode = pwcrc_pkg::MODE_WRAP;
   logic [31:0] cfg_sig = pwcrc_pkg::SIG_RESET;
   logic [7:0]  cfg_key = pwcrc_pkg::KEY_RESET;
   logic [31:0] run_crc = pwcrc_pkg::ALL_ONES;
   logic [31:0] run_count = '0;
   logic        run_match = 1'b1;

   pwcrc_pkg::req_type byte_q[$];
   pwcrc_pkg::rsp_type awaited_rsp_q[$];
   int inflight = 0;
   int idle_pct = 26;
   int fail_count = 0;
   int rsp_checked = 0;
   int ended_ok = 0;
   int ended_short = 0;
   int ended_bad_sig = 0;

   payload_wrap_crc32_xor_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      logic fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c = {1'b0, c[31:1]} ^ (fb ? pwcrc_pkg::CRC_POLY : 32'd0);
      end
      return c;
   endfunction

   // Advances the stream state by one accepted byte and queues the result it causes.
   function automatic void process_byte(input pwcrc_pkg::req_type it);
      pwcrc_pkg::rsp_type r;
      logic [31:0] pos;
      logic [31:0] len;
      logic emit;
      r = '0;
      pos = run_count;
      len = (pos == pwcrc_pkg::ALL_ONES) ? pwcrc_pkg::ALL_ONES : pos + 32'd1;
      if (cfg_mode == pwcrc_pkg::MODE_WRAP) begin
         run_crc = crc32_step(run_crc, it.data_in);
         r.out_valid = 1'b1;
         emit = 1'b1;
         if (it.last_in) r.crc_value = ~run_crc;
      end else begin
         if (pos < 32'd4) begin
            if (cfg_sig[8*pos[1:0] +: 8] != it.data_in) run_match = 1'b0;
         end
         if (pos >= pwcrc_pkg::HEADER_BYTES) r.out_valid = run_match;
         emit = (pos >= pwcrc_pkg::HEADER_BYTES) || it.last_in;
         if (it.last_in) begin
            if (len <= pwcrc_pkg::HEADER_BYTES) r.status = pwcrc_pkg::STATUS_SHORT;
            else if (!run_match) r.status = pwcrc_pkg::STATUS_BAD_SIG;
            else r.status = pwcrc_pkg::STATUS_OK;
         end
      end
      if (r.out_valid) r.out_byte = it.data_in ^ cfg_key;
      r.end_of_stream = it.last_in;
      run_count = len;
      if (it.last_in) begin
         r.byte_length = len;
         run_crc = pwcrc_pkg::ALL_ONES;
         run_count = '0;
         run_match = 1'b1;
      end
      if (emit) awaited_rsp_q.push_back(r);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void compare_rsp(input pwcrc_pkg::rsp_type got);
      pwcrc_pkg::rsp_type want;
      if (awaited_rsp_q.size() == 0) begin
         $error("unexpected result item: %p", got);
         fail_count++;
         return;
      end
      want = awaited_rsp_q.pop_front();
      rsp_checked++;
      if (want.end_of_stream) begin
         case (want.status)
            pwcrc_pkg::STATUS_OK: ended_ok++;
            pwcrc_pkg::STATUS_SHORT: ended_short++;
            default: ended_bad_sig++;
         endcase
      end
      check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      check_field("out_valid", 32'(want.out_valid), 32'(got.out_valid));
      check_field("end_of_stream", 32'(want.end_of_stream), 32'(got.end_of_stream));
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("crc_value", want.crc_value, got.crc_value);
      check_field("byte_length", want.byte_length, got.byte_length);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            process_byte(req_data);
            inflight--;
         end
         if (!req_valid || req_ready) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data <= byte_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) compare_rsp(rsp_data);
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      pwcrc_pkg::req_type it;
      it.data_in = b;
      it.last_in = last;
      byte_q.push_back(it);
      inflight++;
   endtask

   task automatic wrap_stream(input int len);
      for (int i = 0; i < len; i++) push_byte(8'($urandom_range(255)), i == len - 1);
   endtask

   // A container of total bytes; the signature bytes match unless bad is set.
   task automatic send_container(input int total, input bit bad);
      int k;
      logic [7:0] b;
      k = $urandom_range(3);
      for (int p = 0; p < total; p++) begin
         if (p < 4) begin
            b = cfg_sig[8*p +: 8];
            if (bad && p == k) b = b ^ 8'($urandom_range(1, 255));
         end else begin
            b = 8'($urandom_range(255));
         end
         push_byte(b, p == total - 1);
      end
   endtask

   // Waits until every queued item is taken and every result has come back.
   task automatic settle();
      int waited;
      waited = 0;
      while (inflight != 0) @(posedge clock);
      while (awaited_rsp_q.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      if (awaited_rsp_q.size() != 0) begin
         $error("%0d result items never arrived", awaited_rsp_q.size());
         fail_count++;
         awaited_rsp_q.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [pwcrc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         pwcrc_pkg::REG_WRAP_MODE: cfg_mode = val[0];
         pwcrc_pkg::REG_SIGNATURE: cfg_sig = val;
         pwcrc_pkg::REG_XOR_KEY: cfg_key = val[7:0];
         default: ;
      endcase
   endtask

   initial begin
      int n;
      int sel;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part, wrap mode with the reset register values.
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h80, 1'b1);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      settle();
      // A write past the last register must leave the others alone.
      csr_write(REG_UNUSED, pwcrc_pkg::ALL_ONES);
      push_byte(8'h5C, 1'b1);
      settle();
      csr_write(pwcrc_pkg::REG_XOR_KEY, 32'hFF);
      push_byte(8'hA5, 1'b0);
      push_byte(8'h3C, 1'b0);
      push_byte(8'hFF, 1'b0);
      settle();
      // Key changed in the middle of a stream; CRC and count carry on.
      csr_write(pwcrc_pkg::REG_XOR_KEY, 32'h00);
      push_byte(8'h7E, 1'b0);
      push_byte(8'h81, 1'b1);
      push_byte(8'h11, 1'b0);
      push_byte(8'h22, 1'b0);
      settle();
      // Mode switched mid-stream: the count continues into the signature bytes.
      csr_write(pwcrc_pkg::REG_WRAP_MODE, 32'(pwcrc_pkg::MODE_UNWRAP));
      push_byte(cfg_sig[23:16], 1'b0);
      push_byte(cfg_sig[31:24], 1'b0);
      push_byte(8'h99, 1'b1);
      send_container(1, 1'b0);
      send_container(HDR, 1'b0);
      send_container(HDR + 2, 1'b1);
      settle();
      csr_write(pwcrc_pkg::REG_SIGNATURE, 32'h0000_0000);
      csr_write(pwcrc_pkg::REG_XOR_KEY, 32'hFF);
      send_container(3, 1'b1);
      settle();
      csr_write(pwcrc_pkg::REG_SIGNATURE, pwcrc_pkg::ALL_ONES);
      csr_write(pwcrc_pkg::REG_XOR_KEY, 32'h00);
      send_container(4, 1'b0);
      settle();

      // Random wrap streams under several keys; one setting runs without idling.
      csr_write(pwcrc_pkg::REG_WRAP_MODE, 32'(pwcrc_pkg::MODE_WRAP));
      for (int s = 0; s < 4; s++) begin
         csr_write(pwcrc_pkg::REG_XOR_KEY, $urandom_range(255));
         csr_write(pwcrc_pkg::REG_SIGNATURE, $urandom);
         idle_pct = (s == 1) ? 0 : 26;
         n = 0;
         while (n < 40) begin
            sel = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 40);
            wrap_stream(sel);
            n += sel;
         end
         settle();
      end
      idle_pct = 26;

      // A random well-formed container, then a few short ones, some with a bad signature.
      csr_write(pwcrc_pkg::REG_WRAP_MODE, 32'(pwcrc_pkg::MODE_UNWRAP));
      csr_write(pwcrc_pkg::REG_SIGNATURE, $urandom);
      csr_write(pwcrc_pkg::REG_XOR_KEY, $urandom_range(255));
      send_container(HDR + $urandom_range(1, 40), 1'b0);
      for (int s = 0; s < 4; s++) begin
         send_container($urandom_range(1, 12), 1'($urandom_range(1)));
      end
      settle();

      $display("checked %0d result items; streams ended ok %0d, short %0d, bad signature %0d",
               rsp_checked, ended_ok, ended_short, ended_bad_sig);
      if (fail_count == 0) begin
         $display("payload_wrap_crc32_xor_top regression: pass");
      end else begin
         $display("payload_wrap_crc32_xor_top regression: fail");
      end
      $finish;
   end

   initial begin
      #500_000;
      $display("timeout with %0d items still queued", inflight);
      $display("payload_wrap_crc32_xor_top regression: fail");
      $finish;
   end

endmodule
